>>> hdl/utf16_to_utf8_transcoder_assert.svh
// Assertion macros for the UTF-16 to UTF-8 transcoder.
// Included by the top level; uses the i_clk and i_rst_n ports of the including module.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U2U8_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u2u8: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define U2U8_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u2u8: next-cycle check failed");

`endif

>>> hdl/u2u8_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package u2u8_pkg;

    localparam int unsigned ModeW  = 2;
    localparam int unsigned PendW  = 6;
    localparam int unsigned TotalW = PendW + 1;

    localparam logic [ModeW-1:0] MODE_PASS      = 2'd0;
    localparam logic [ModeW-1:0] MODE_HI_FIRST  = 2'd1;
    localparam logic [ModeW-1:0] MODE_HI_SECOND = 2'd2;

    localparam logic [7:0] SPACE_BYTE = 8'h20;

    typedef struct packed {
        logic [2:0][7:0]  bytes;
        logic [1:0]       nb;
        logic [PendW-1:0] pad;
        logic             last;
    } t_burst;

    function automatic logic [7:0] pick_byte(input logic [2:0][7:0] bytes,
                                             input logic [1:0] sel);
        logic [7:0] b;
        begin
            case (sel)
                2'd0:    b = bytes[0];
                2'd1:    b = bytes[1];
                default: b = bytes[2];
            endcase
            return b;
        end
    endfunction

endpackage

>>> hdl/u2u8_encode.sv
`timescale 1ns / 1ps
// Input register, string state and UTF-8 encoding (or passthrough) of one code unit.
// Depends on u2u8_pkg.
module u2u8_encode #(
    parameter int unsigned MAX_STRING_BYTES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [u2u8_pkg::ModeW-1:0]  i_mode,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_first_byte,
    input  logic [7:0]                  i_second_byte,
    input  logic                        i_last_unit,
    input  logic                        i_take,
    output logic                        o_burst_valid,
    output u2u8_pkg::t_burst            o_burst
);

    localparam int unsigned HalfLen  = MAX_STRING_BYTES / 2;
    localparam int unsigned LimitInt = (HalfLen > 63) ? 63 : HalfLen;
    localparam logic [u2u8_pkg::PendW-1:0] PendLimit = u2u8_pkg::PendW'(LimitInt);

    logic                       r_valid;
    logic [7:0]                 r_b0;
    logic [7:0]                 r_b1;
    logic                       r_last;
    logic [u2u8_pkg::PendW-1:0] r_pending;
    logic                       r_zero_seen;

    logic [u2u8_pkg::PendW-1:0] n_pending;
    logic                       n_zero_seen;
    logic [15:0]                s;
    logic                       encode;
    logic                       zero_now;
    logic [2:0][7:0]            enc_bytes;
    logic [1:0]                 enc_nb;
    logic                       accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        encode = 1'b1;
        s      = {r_b0, r_b1};
        unique case (i_mode)
            u2u8_pkg::MODE_HI_FIRST:  s = {r_b0, r_b1};
            u2u8_pkg::MODE_HI_SECOND: s = {r_b1, r_b0};
            default:                  encode = 1'b0;
        endcase
    end

    always_comb begin
        n_pending   = r_pending;
        n_zero_seen = r_zero_seen;
        enc_bytes   = {r_b0, r_b1, r_b0};
        enc_nb      = 2'd2;
        zero_now    = 1'b0;
        if (!encode) begin
            enc_bytes = {8'h00, r_b1, r_b0};
            enc_nb    = 2'd2;
        end else begin
            if (s < 16'h0080) begin
                enc_bytes = {8'h00, 8'h00, s[7:0]};
                enc_nb    = 2'd1;
                if (r_pending < PendLimit) begin
                    n_pending = r_pending + 1'b1;
                end
            end else if (s <= 16'h07FF) begin
                enc_bytes = {8'h00, 8'h80 | {2'b00, s[5:0]}, 8'hC0 | {3'b000, s[10:6]}};
                enc_nb    = 2'd2;
            end else begin
                enc_bytes = {8'h80 | {2'b00, s[5:0]}, 8'h80 | {2'b00, s[11:6]},
                             8'hE0 | {4'b0000, s[15:12]}};
                enc_nb    = 2'd3;
            end
            zero_now    = r_zero_seen || (s == 16'h0000);
            n_zero_seen = zero_now;
            if (zero_now) begin
                enc_bytes = {u2u8_pkg::SPACE_BYTE, u2u8_pkg::SPACE_BYTE,
                             u2u8_pkg::SPACE_BYTE};
            end
        end
    end

    always_comb begin
        o_burst_valid = r_valid;
        o_burst.bytes = enc_bytes;
        o_burst.nb    = enc_nb;
        o_burst.pad   = (encode && r_last) ? n_pending : '0;
        o_burst.last  = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_pending   <= '0;
            r_zero_seen <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
            if (i_take) begin
                if (r_last) begin
                    r_pending   <= '0;
                    r_zero_seen <= 1'b0;
                end else begin
                    r_pending   <= n_pending;
                    r_zero_seen <= n_zero_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b0   <= i_first_byte;
            r_b1   <= i_second_byte;
            r_last <= i_last_unit;
        end
    end

endmodule

>>> hdl/u2u8_serial.sv
`timescale 1ns / 1ps
// Byte sequencer and output register: sends one beat per encoded or padding byte.
// Depends on u2u8_pkg.
module u2u8_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_burst_valid,
    input  u2u8_pkg::t_burst  i_burst,
    output logic              o_take,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_byte
);

    logic [u2u8_pkg::TotalW-1:0] r_idx;
    logic                        r_o_valid;
    logic [7:0]                  r_o_byte;
    logic                        r_o_last;

    logic [u2u8_pkg::TotalW-1:0] total;
    logic                        out_free;
    logic                        emit;
    logic                        elem_final;
    logic [7:0]                  cur_byte;

    assign total      = u2u8_pkg::TotalW'(i_burst.nb) + u2u8_pkg::TotalW'(i_burst.pad);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign emit       = i_burst_valid && out_free;
    assign elem_final = (r_idx == total - 1'b1);
    assign o_take     = emit && elem_final;
    assign cur_byte   = (r_idx < u2u8_pkg::TotalW'(i_burst.nb))
                        ? u2u8_pkg::pick_byte(i_burst.bytes, r_idx[1:0])
                        : u2u8_pkg::SPACE_BYTE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_byte <= cur_byte;
            r_o_last <= i_burst.last && elem_final;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_last_byte = r_o_last;

endmodule

>>> hdl/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-16 to UTF-8 transcoder: mode register, encoder and byte sequencer.
// Depends on u2u8_pkg, u2u8_encode, u2u8_serial and utf16_to_utf8_transcoder_assert.svh.
//
//  Channel | Direction | Handshake               | Beat payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | in        | i_in_valid / o_in_stall | i_first_byte, i_second_byte, i_last_unit
//  out     | out       | o_out_valid/i_out_stall | o_out_byte, o_last_byte
//  cfg     | in        | i_cfg_we                | i_cfg_wdata (trans_mode)
//
// A code unit takes one output beat per byte it produces: one to three, two in
// passthrough, plus, outside passthrough, the padding spaces on the last unit of
// a string. The one-byte output channel sets the rate; the first byte of a unit
// passes through the input register and then the output register.
// Reset is synchronous and clears the mode, the string state and both valid flags.
// Stalls on the output hold the output register and back up into the input register.
module utf16_to_utf8_transcoder #(
    parameter int unsigned MAX_STRING_BYTES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [u2u8_pkg::ModeW-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_first_byte,
    input  logic [7:0]                 i_second_byte,
    input  logic                       i_last_unit,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_last_byte
);

    logic [u2u8_pkg::ModeW-1:0] r_trans_mode;
    logic                       w_take;
    logic                       w_burst_valid;
    u2u8_pkg::t_burst           w_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_mode <= u2u8_pkg::MODE_PASS;
        end else if (i_cfg_we) begin
            r_trans_mode <= i_cfg_wdata;
        end
    end

    u2u8_encode #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_encode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_trans_mode),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_first_byte  (i_first_byte),
        .i_second_byte (i_second_byte),
        .i_last_unit   (i_last_unit),
        .i_take        (w_take),
        .o_burst_valid (w_burst_valid),
        .o_burst       (w_burst)
    );

    u2u8_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (w_burst_valid),
        .i_burst       (w_burst),
        .o_take        (w_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte)
    );

`include "utf16_to_utf8_transcoder_assert.svh"

    `U2U8_ASSERT_NOW(a_take_needs_burst, w_take, w_burst_valid)
    `U2U8_ASSERT_NEXT(a_take_loads_output, w_take, o_out_valid)
    `U2U8_ASSERT_NEXT(a_burst_held, w_burst_valid && !w_take, w_burst_valid)

endmodule
